>>> rtl/core/lkv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg: shared types for the lru key-value cache
// Request and response words, controller states, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam logic        REQ_GET    = 1'b0;
    localparam logic        REQ_SET    = 1'b1;
    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [4:0]  CAP_RESET  = 5'd16;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               hit;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_UPD,
        ST_UPD_END,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic upd;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic is_set;
    } status_t;

endpackage
`default_nettype wire

>>> rtl/core/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, lru replacement
// Top level joining the request sequencer and the datapath.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; busy stays high
// until its response word has been shown. The response is on rsp for exactly
// one cycle with done high, and the receiver cannot stall it. Each request
// walks the key and rank rams one entry per cycle: a get scans them once,
// then decides and responds; a set also makes a second walk, the
// read-modify-write of the rank ram. Capacity is written through cfg_valid/
// cfg_data; the user must write it only while no request is in flight, the
// block does not enforce this. Zero acts as one, above ENTRIES as ENTRIES.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire lkv_pkg::req_t req,
    output logic               done,
    output lkv_pkg::rsp_t      rsp,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [4:0]    cfg_data
);

    import lkv_pkg::*;

    cmd_t    cmd;
    status_t status;

    lkv_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd)
    );

    lkv_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

>>> rtl/core/lkv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_ram: generic simple dual-port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/lkv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_ctrl: request sequencer
// Steps one request through the tag scan, the decision, the rank update
// pass (for a set only) and the response cycle.
// ----------------------------------------------------------------------------
module lkv_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output logic                  done,
    input  wire lkv_pkg::status_t status,
    output lkv_pkg::cmd_t         cmd
);

    import lkv_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.is_set ? ST_UPD : ST_RESP;
            end
            ST_UPD:
            begin
                cmd.issue = 1'b1;
                cmd.upd   = 1'b1;
                if (status.last)
                begin
                    state_next = ST_UPD_END;
                end
            end
            ST_UPD_END:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/lkv_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_dp: cache datapath
// Key, data and rank rams, valid bits, occupancy, capacity register, scan
// trackers and the response word.
// ----------------------------------------------------------------------------
module lkv_dp #(
    parameter int ENTRIES = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lkv_pkg::req_t    req,
    output lkv_pkg::rsp_t         rsp,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [4:0]       cfg_data,
    input  wire lkv_pkg::cmd_t    cmd,
    output lkv_pkg::status_t      status
);

    import lkv_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > 5) ? OW : 5;

    // control state
    logic [AW-1:0]      idx_reg,        idx_next;
    logic               chk_vld_reg;
    logic               chk_upd_reg;
    logic [ENTRIES-1:0] valid_reg,      valid_next;
    logic [OW-1:0]      occ_reg,        occ_next;
    logic [4:0]         cap_reg;
    logic               hit_reg,        hit_next;
    logic               lru_found_reg,  lru_found_next;
    logic               free_found_reg, free_found_next;
    logic               ev_reg,         ev_next;

    // payload
    logic [AW-1:0]      chk_idx_reg;
    req_t               req_reg;
    logic [AW-1:0]      match_reg,      match_next;
    logic [AW-1:0]      match_rank_reg, match_rank_next;
    logic [AW-1:0]      lru_idx_reg,    lru_idx_next;
    logic [AW-1:0]      lru_rank_reg,   lru_rank_next;
    logic [31:0]        lru_key_reg,    lru_key_next;
    logic [AW-1:0]      free_idx_reg,   free_idx_next;
    logic [AW-1:0]      target_reg,     target_next;
    logic [31:0]        evk_reg,        evk_next;

    logic [31:0]   key_rdata;
    logic [31:0]   data_rdata;
    logic [AW-1:0] rank_rdata;
    logic          key_we;
    logic          data_we;
    logic          rank_we;
    logic [AW-1:0] rank_wdata;
    logic [AW-1:0] tgt;
    logic [CW-1:0] cap_ext;
    logic [CW-1:0] cap_eff;
    logic          evict;
    logic          chk_valid;
    logic          is_set;

    assign is_set    = (req_reg.req_type == REQ_SET);
    assign cfg_ready = 1'b1;
    assign chk_valid = valid_reg[chk_idx_reg];

    assign status.last   = (idx_reg == AW'(ENTRIES - 1));
    assign status.is_set = is_set;

    // capacity clamped to 1 .. ENTRIES
    always_comb
    begin
        cap_ext = CW'(cap_reg);
        priority if (cap_ext == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cap_ext > CW'(ENTRIES))
        begin
            cap_eff = CW'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign evict = !hit_reg && lru_found_reg && (CW'(occ_reg) >= cap_eff);

    // slot that the set writes: the hit slot, else lowest invalid slot after any eviction
    always_comb
    begin
        priority if (hit_reg)
        begin
            tgt = match_reg;
        end
        else if (evict)
        begin
            tgt = (free_found_reg && (free_idx_reg < lru_idx_reg)) ? free_idx_reg
                                                                   : lru_idx_reg;
        end
        else
        begin
            tgt = free_idx_reg;
        end
    end

    assign key_we  = cmd.decide && is_set && !hit_reg;
    assign data_we = cmd.decide && is_set;
    assign rank_we = chk_vld_reg && chk_upd_reg;

    // rank update: touched slot becomes 0, younger entries age by one (all valid ones on a miss)
    always_comb
    begin
        priority if (chk_idx_reg == target_reg)
        begin
            rank_wdata = '0;
        end
        else if (chk_valid && (!hit_reg || (rank_rdata < match_rank_reg)))
        begin
            rank_wdata = rank_rdata + AW'(1);
        end
        else
        begin
            rank_wdata = rank_rdata;
        end
    end

    always_comb
    begin
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        hit_next        = hit_reg;
        lru_found_next  = lru_found_reg;
        free_found_next = free_found_reg;
        ev_next         = ev_reg;
        match_next      = match_reg;
        match_rank_next = match_rank_reg;
        lru_idx_next    = lru_idx_reg;
        lru_rank_next   = lru_rank_reg;
        lru_key_next    = lru_key_reg;
        free_idx_next   = free_idx_reg;
        target_next     = target_reg;
        evk_next        = evk_reg;

        if (cmd.issue)
        begin
            idx_next = status.last ? '0 : idx_reg + AW'(1);
        end

        if (cmd.load)
        begin
            hit_next        = 1'b0;
            lru_found_next  = 1'b0;
            free_found_next = 1'b0;
        end

        // scan check, in the cycle after the ram read of each entry
        if (chk_vld_reg && !chk_upd_reg)
        begin
            if (chk_valid && (key_rdata == req_reg.key) && !hit_reg)
            begin
                hit_next        = 1'b1;
                match_next      = chk_idx_reg;
                match_rank_next = rank_rdata;
            end
            if (chk_valid && (!lru_found_reg || (rank_rdata > lru_rank_reg)))
            begin
                lru_found_next = 1'b1;
                lru_idx_next   = chk_idx_reg;
                lru_rank_next  = rank_rdata;
                lru_key_next   = key_rdata;
            end
            if (!chk_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = chk_idx_reg;
            end
        end

        if (cmd.decide)
        begin
            ev_next     = is_set && evict;
            evk_next    = (is_set && evict) ? lru_key_reg : '0;
            target_next = tgt;
            if (is_set && !hit_reg)
            begin
                if (evict)
                begin
                    valid_next[lru_idx_reg] = 1'b0;
                end
                else
                begin
                    occ_next = occ_reg + OW'(1);
                end
                valid_next[tgt] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            chk_upd_reg    <= 1'b0;
            valid_reg      <= '0;
            occ_reg        <= '0;
            cap_reg        <= CAP_RESET;
            hit_reg        <= 1'b0;
            lru_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            ev_reg         <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            chk_vld_reg    <= cmd.issue;
            chk_upd_reg    <= cmd.upd;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            hit_reg        <= hit_next;
            lru_found_reg  <= lru_found_next;
            free_found_reg <= free_found_next;
            ev_reg         <= ev_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= idx_reg;
        match_reg      <= match_next;
        match_rank_reg <= match_rank_next;
        lru_idx_reg    <= lru_idx_next;
        lru_rank_reg   <= lru_rank_next;
        lru_key_reg    <= lru_key_next;
        free_idx_reg   <= free_idx_next;
        target_reg     <= target_next;
        evk_reg        <= evk_next;
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    lkv_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (tgt),
        .wdata (req_reg.key),
        .raddr (idx_reg),
        .rdata (key_rdata)
    );

    lkv_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (tgt),
        .wdata (req_reg.value),
        .raddr (match_reg),
        .rdata (data_rdata)
    );

    lkv_ram #(
        .WIDTH (AW),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (chk_idx_reg),
        .wdata (rank_wdata),
        .raddr (idx_reg),
        .rdata (rank_rdata)
    );

    // data ram read address settles on the hit slot before the response cycle
    always_comb
    begin
        rsp.hit         = hit_reg;
        rsp.evicted     = ev_reg;
        rsp.evicted_key = evk_reg;
        if (is_set)
        begin
            rsp.read_value = '0;
        end
        else if (hit_reg)
        begin
            rsp.read_value = data_rdata;
        end
        else
        begin
            rsp.read_value = MISS_VALUE;
        end
    end

endmodule
`default_nettype wire
